// ===== rtl/core/knn_sorted_neighbour_list_unit_defines.svh =====
// assertion macros for the sorted neighbour list unit
// used by the port checker; expects clk and rst in the including scope
`ifndef KNN_SORTED_NEIGHBOUR_LIST_UNIT_DEFINES_SVH
`define KNN_SORTED_NEIGHBOUR_LIST_UNIT_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define KNNSL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define KNNSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/knnsl_pkg.sv =====
// shared types and constants for the sorted neighbour list unit
// no dependencies
package knnsl_pkg;

  // list geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // item field widths
  localparam int DIST_W   = 32;
  localparam int CLASS_W  = 8;
  localparam int OCNT_W   = 5;
  localparam int NCNT_W   = 5;
  localparam int CMP_W    = (CNT_W > NCNT_W) ? CNT_W : NCNT_W;

  // configuration port
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic [PADDR_W-3:0] REG_NEIGHBOUR_COUNT = '0;
  localparam logic [NCNT_W-1:0]  NEIGHBOUR_COUNT_RESET = 5'd15;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CHECK  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    func_t               func;
    logic [DIST_W-1:0]   new_distance;
    logic [CLASS_W-1:0]  new_class;
    logic [CLASS_W-1:0]  query_class;
  } in_item_t;

  typedef struct packed {
    status_t             op_status;
    logic [OCNT_W-1:0]   stored_count;
    logic [DIST_W-1:0]   head_distance;
    logic [CLASS_W-1:0]  head_class;
    logic [OCNT_W-1:0]   mismatch_count;
    logic                error_flag;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic apply;       // run insert, remove or clear and load the result
    logic scan_start;  // begin a class scan
    logic scan_step;   // compare one stored class
    logic finish;      // load the scan result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_check;    // offered item is a check error
    logic scan_done;   // scan index reached the entry count
  } dp_status_t;

endpackage

// ===== rtl/core/knnsl_ctrl.sv =====
// controller for the sorted neighbour list unit: item handshake and scan sequencing
// depends on knnsl_pkg
module knnsl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  knnsl_pkg::dp_status_t status,
  output knnsl_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;
  logic   load;
  logic   out_valid_next;

  // output slot can take a result this cycle
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // commands
  always_comb begin
    cmd            = '0;
    cmd.apply      = accept && !status.is_check;
    cmd.scan_start = accept && status.is_check;
    cmd.scan_step  = (state == ST_SCAN) && !status.scan_done;
    cmd.finish     = (state == ST_SCAN) && status.scan_done && out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.scan_start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cmd.finish) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output valid
  assign load = cmd.apply || cmd.finish;
  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/core/knnsl_datapath.sv =====
// datapath for the sorted neighbour list unit: entry cells, class scan, result register
// depends on knnsl_pkg
module knnsl_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  knnsl_pkg::in_item_t               in_item,
  input  logic [knnsl_pkg::NCNT_W-1:0]      neighbour_count,
  input  knnsl_pkg::dp_cmd_t                cmd,
  output knnsl_pkg::dp_status_t             status,
  output knnsl_pkg::out_item_t              out_item
);

  localparam int CAP = knnsl_pkg::CAPACITY;

  // entry cells, sorted by descending distance
  logic [knnsl_pkg::DIST_W-1:0]  ent_dist  [CAP];
  logic [knnsl_pkg::CLASS_W-1:0] cls       [CAP];
  logic [knnsl_pkg::DIST_W-1:0]  dist_next [CAP];
  logic [knnsl_pkg::CLASS_W-1:0] cls_next  [CAP];
  logic [knnsl_pkg::DIST_W-1:0]  dist_prev [CAP];
  logic [knnsl_pkg::CLASS_W-1:0] cls_prev  [CAP];
  logic [knnsl_pkg::DIST_W-1:0]  dist_succ [CAP];
  logic [knnsl_pkg::CLASS_W-1:0] cls_succ  [CAP];
  logic [knnsl_pkg::CNT_W-1:0]   count;
  logic [knnsl_pkg::CNT_W-1:0]   count_next;
  knnsl_pkg::status_t            op_status;

  // insert position marks
  logic [CAP-1:0] at_or_after;
  logic [CAP-1:0] at_or_after_prev;

  // scan state
  logic [knnsl_pkg::CNT_W-1:0]   scan_idx;
  logic [knnsl_pkg::CNT_W-1:0]   mism;
  logic [knnsl_pkg::CLASS_W-1:0] query;
  logic                          flag;

  // per cell: new entry lands here or later (beyond fill, or distance not above new)
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      at_or_after[i] = (knnsl_pkg::CNT_W'(i) >= count) ||
                       (ent_dist[i] <= in_item.new_distance);
    end
  end
  assign at_or_after_prev = {at_or_after[CAP-2:0], 1'b0};

  // neighbor taps for shifting
  for (genvar g = 0; g < CAP; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign dist_prev[g] = ent_dist[g];
      assign cls_prev[g]  = cls[g];
    end else begin : g_rest
      assign dist_prev[g] = ent_dist[g-1];
      assign cls_prev[g]  = cls[g-1];
    end
    if (g == CAP - 1) begin : g_last
      assign dist_succ[g] = ent_dist[g];
      assign cls_succ[g]  = cls[g];
    end else begin : g_inner
      assign dist_succ[g] = ent_dist[g+1];
      assign cls_succ[g]  = cls[g+1];
    end
  end

  // list update for insert, remove and clear
  always_comb begin
    dist_next  = ent_dist;
    cls_next   = cls;
    count_next = count;
    op_status  = knnsl_pkg::STATUS_OK;
    case (in_item.func)
      knnsl_pkg::FUNC_INSERT: begin
        if (count == knnsl_pkg::CNT_W'(CAP)) begin
          op_status = knnsl_pkg::STATUS_FULL;
        end else begin
          for (int i = 0; i < CAP; i++) begin
            if (at_or_after[i] && !at_or_after_prev[i]) begin
              dist_next[i] = in_item.new_distance;
              cls_next[i]  = in_item.new_class;
            end else if (at_or_after[i]) begin
              dist_next[i] = dist_prev[i];
              cls_next[i]  = cls_prev[i];
            end
          end
          count_next = count + knnsl_pkg::CNT_W'(1);
        end
      end
      knnsl_pkg::FUNC_REMOVE: begin
        if (count == '0) begin
          op_status = knnsl_pkg::STATUS_EMPTY;
        end else begin
          for (int i = 0; i < CAP; i++) begin
            dist_next[i] = dist_succ[i];
            cls_next[i]  = cls_succ[i];
          end
          count_next = count - knnsl_pkg::CNT_W'(1);
        end
      end
      knnsl_pkg::FUNC_CHECK: begin
        count_next = count;
      end
      knnsl_pkg::FUNC_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // status back to the controller
  assign status.is_check  = (in_item.func == knnsl_pkg::FUNC_CHECK);
  assign status.scan_done = (scan_idx == count);

  // error flag against half the neighbour count
  assign flag = knnsl_pkg::CMP_W'(mism) > knnsl_pkg::CMP_W'(neighbour_count >> 1);

  // entry cells
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      ent_dist <= dist_next;
      cls      <= cls_next;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      count <= count_next;
    end
  end

  // class scan, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      mism     <= '0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
      mism     <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + knnsl_pkg::CNT_W'(1);
      if (cls[scan_idx[knnsl_pkg::IDX_W-1:0]] != query) begin
        mism <= mism + knnsl_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      query <= in_item.query_class;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_item.op_status      <= op_status;
      out_item.stored_count   <= knnsl_pkg::OCNT_W'(count_next);
      out_item.head_distance  <= (count_next != '0) ? dist_next[0] : '0;
      out_item.head_class     <= (count_next != '0) ? cls_next[0] : '0;
      out_item.mismatch_count <= '0;
      out_item.error_flag     <= 1'b0;
    end else if (cmd.finish) begin
      out_item.op_status      <= knnsl_pkg::STATUS_OK;
      out_item.stored_count   <= knnsl_pkg::OCNT_W'(count);
      out_item.head_distance  <= (count != '0) ? ent_dist[0] : '0;
      out_item.head_class     <= (count != '0) ? cls[0] : '0;
      out_item.mismatch_count <= knnsl_pkg::OCNT_W'(mism);
      out_item.error_flag     <= flag;
    end
  end

endmodule

// ===== rtl/core/knn_sorted_neighbour_list_unit.sv =====
// Sorted kNN candidate list holding up to knnsl_pkg::CAPACITY (distance, class) entries in
// descending distance order. Insert, remove-largest and clear update the entry cells by a
// parallel compare-and-shift and are accepted every cycle while no scan runs and the output
// register is free; their result is registered on acceptance. A check-error item walks the
// stored classes through one shared comparator, one entry per cycle, and occupies the block
// until its result is loaded; only then is the next item taken. Results wait in a single
// output register; a pending result does not block the next item unless out_stall is held.
// The neighbour_count register (byte address 0, reset 15) sets the error threshold and must
// be written only while the block is idle. The list is empty after reset; no clearing pass.
// top level; depends on knnsl_pkg, knnsl_ctrl, knnsl_datapath
module knn_sorted_neighbour_list_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  knnsl_pkg::in_item_t              in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output knnsl_pkg::out_item_t             out_item,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [knnsl_pkg::PADDR_W-1:0]    paddr,
  input  logic [knnsl_pkg::PDATA_W-1:0]    pwdata,
  output logic [knnsl_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready
);

  logic [knnsl_pkg::NCNT_W-1:0] neighbour_count;
  logic                         reg_hit;
  knnsl_pkg::dp_cmd_t           cmd;
  knnsl_pkg::dp_status_t        status;

  // register decode
  assign pready  = 1'b1;
  assign reg_hit = (paddr[knnsl_pkg::PADDR_W-1:2] == knnsl_pkg::REG_NEIGHBOUR_COUNT);
  assign prdata  = reg_hit ? knnsl_pkg::PDATA_W'(neighbour_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbour_count <= knnsl_pkg::NEIGHBOUR_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      neighbour_count <= pwdata[knnsl_pkg::NCNT_W-1:0];
    end
  end

  knnsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  knnsl_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .in_item         (in_item),
    .neighbour_count (neighbour_count),
    .cmd             (cmd),
    .status          (status),
    .out_item        (out_item)
  );

endmodule

// ===== rtl/core/knnsl_checker.sv =====
// port checker for the sorted neighbour list unit, bound to the top level
// depends on knnsl_pkg and knn_sorted_neighbour_list_unit_defines.svh
`include "knn_sorted_neighbour_list_unit_defines.svh"

module knnsl_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  knnsl_pkg::in_item_t  in_item,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  knnsl_pkg::out_item_t out_item
);

  // a stalled input item stays put
  `KNNSL_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable(in_item), "input item changed while stalled")

  // a held result stays put
  `KNNSL_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_item), "result changed while stalled")

  // an empty list reports a zero head
  `KNNSL_ASSERT_SAME(a_empty_head, out_valid && (out_item.stored_count == '0),
    (out_item.head_distance == '0) && (out_item.head_class == '0),
    "nonzero head on empty list")

  // refused operations carry no check result
  `KNNSL_ASSERT_SAME(a_refused_clean,
    out_valid && (out_item.op_status != knnsl_pkg::STATUS_OK),
    (out_item.mismatch_count == '0) && !out_item.error_flag,
    "check fields set on refused item")

  // the flag needs at least one mismatch
  `KNNSL_ASSERT_SAME(a_flag_count, out_valid && out_item.error_flag,
    out_item.mismatch_count != '0, "error flag without mismatches")

endmodule

bind knn_sorted_neighbour_list_unit knnsl_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
